@@ rtl/core/l2_learning_switch_forwarder_core_defines.svh @@
// ----------------------------------------------------------------------------
// L2 forwarder assertion macros
// Concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef L2_LEARNING_SWITCH_FORWARDER_CORE_DEFINES_SVH
`define L2_LEARNING_SWITCH_FORWARDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define L2FWD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("l2fwd check failed");
`define L2FWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("l2fwd check failed");
`else
`define L2FWD_ASSERT_NOW(label, ante, cons)
`define L2FWD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/l2fwd_pkg.sv @@
// ----------------------------------------------------------------------------
// L2 forwarder package
// Shared widths, codes and types of the learning switch forwarder.
// ----------------------------------------------------------------------------
package l2fwd_pkg;

  localparam int NUM_PORTS        = 4;
  localparam int TABLE_ENTRIES    = 64;
  localparam int TRUNK_VLAN_SLOTS = 4;

  localparam int MAC_W      = 48;
  localparam int VID_W      = 12;
  localparam int PORT_W     = 2;
  localparam int MODE_W     = 2;
  localparam int MASK_PORTS = 4;
  localparam int REG_W      = 48;
  localparam int MODE_REG_W = 8;
  localparam int REG_SLOTS  = REG_W / VID_W;
  localparam int SLOTS_USED = (TRUNK_VLAN_SLOTS < REG_SLOTS) ? TRUNK_VLAN_SLOTS : REG_SLOTS;
  localparam int TRUNK_REGS = 4;
  localparam int APB_DW     = 64;
  localparam int APB_AW     = 6;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRUNK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_L3      = 2'd3;

  localparam logic [2:0] REG_PORT_MODE   = 3'd0;
  localparam logic [2:0] REG_ACCESS_VLAN = 3'd1;
  localparam logic [2:0] REG_TRUNK0      = 3'd2;
  localparam logic [2:0] REG_TRUNK1      = 3'd3;
  localparam logic [2:0] REG_TRUNK2      = 3'd4;
  localparam logic [2:0] REG_TRUNK3      = 3'd5;

  typedef struct packed {
    logic [MAC_W-1:0]  key;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef logic [TRUNK_REGS-1:0][REG_W-1:0] trunk_set_t;

  typedef struct packed {
    logic              flood;
    logic              hit;
    logic [PORT_W-1:0] hit_port;
    logic [PORT_W-1:0] ingress;
    logic              has_tag;
    logic [VID_W-1:0]  vid;
  } fwd_req_t;

endpackage

@@ rtl/core/l2fwd_table_ram.sv @@
// ----------------------------------------------------------------------------
// L2 forwarder address table RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module l2fwd_table_ram #(
  parameter int DEPTH = l2fwd_pkg::TABLE_ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  l2fwd_pkg::entry_t    wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output l2fwd_pkg::entry_t    rd_data
);

  l2fwd_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/l2fwd_egress_filter.sv @@
// ----------------------------------------------------------------------------
// L2 forwarder egress filter
// Builds the port mask from candidate ports and access/trunk VLAN rules.
// ----------------------------------------------------------------------------
module l2fwd_egress_filter (
  input  l2fwd_pkg::fwd_req_t                       req,
  input  logic [l2fwd_pkg::MODE_REG_W-1:0]          port_mode,
  input  logic [l2fwd_pkg::REG_W-1:0]               access_vlan,
  input  l2fwd_pkg::trunk_set_t                     trunk_vlans,
  output logic [l2fwd_pkg::MASK_PORTS-1:0]          mask
);

  always_comb begin
    logic [l2fwd_pkg::MODE_W-1:0] mode;
    logic [l2fwd_pkg::VID_W-1:0]  av;
    logic                         cand;
    logic                         allow;
    logic                         trunk_hit;
    mask = '0;
    for (int p = 0; p < l2fwd_pkg::MASK_PORTS; p++) begin
      mode = port_mode[l2fwd_pkg::MODE_W*p +: l2fwd_pkg::MODE_W];
      av   = access_vlan[l2fwd_pkg::VID_W*p +: l2fwd_pkg::VID_W];
      trunk_hit = 1'b0;
      for (int s = 0; s < l2fwd_pkg::SLOTS_USED; s++) begin
        if (trunk_vlans[p][l2fwd_pkg::VID_W*s +: l2fwd_pkg::VID_W] == req.vid) begin
          trunk_hit = 1'b1;
        end
      end
      case (mode)
        l2fwd_pkg::MODE_ACCESS: allow = req.has_tag && (av != '0) && (av == req.vid);
        l2fwd_pkg::MODE_TRUNK:  allow = req.has_tag && (req.vid != '0) && trunk_hit;
        default:                allow = 1'b0;
      endcase
      if (req.hit) begin
        cand = (req.hit_port == l2fwd_pkg::PORT_W'(p));
      end else begin
        cand = (req.ingress != l2fwd_pkg::PORT_W'(p)) && (mode != l2fwd_pkg::MODE_L3);
      end
      mask[p] = (p < l2fwd_pkg::NUM_PORTS) && cand && allow;
    end
  end

endmodule

@@ rtl/core/l2_learning_switch_forwarder_core.sv @@
// ----------------------------------------------------------------------------
// L2 learning switch forwarder core
// On start it scans the learned entries (1..TABLE_ENTRIES), or skips the scan when the
// table is empty; one table read per cycle, then a write state learns the source MAC.
// A start is taken only while idle; busy is low in the done cycle.
// Reset clears the table fill count (table empty) and all config registers.
// ----------------------------------------------------------------------------
`include "l2_learning_switch_forwarder_core_defines.svh"

module l2_learning_switch_forwarder_core #(
  parameter int TABLE_ENTRIES = l2fwd_pkg::TABLE_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [l2fwd_pkg::PORT_W-1:0]         ingress_port,
  input  logic [l2fwd_pkg::MAC_W-1:0]          dst_mac,
  input  logic [l2fwd_pkg::MAC_W-1:0]          src_mac,
  input  logic                                 vlan_tagged,
  input  logic [l2fwd_pkg::VID_W-1:0]          vlan_id,
  output logic                                 done,
  output logic [l2fwd_pkg::MASK_PORTS-1:0]     egress_mask,
  output logic                                 flooded,
  output logic                                 dst_hit,
  output logic                                 learn_dropped,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [l2fwd_pkg::APB_AW-1:0]         paddr,
  input  logic [l2fwd_pkg::APB_DW-1:0]         pwdata,
  output logic [l2fwd_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]                          state;
  logic [CW-1:0]                       fill_count;
  logic [CW-1:0]                       scan_addr;
  logic                                rd_valid;
  logic                                rd_last;
  logic [AW-1:0]                       rd_idx;
  logic                                src_found;
  logic [AW-1:0]                       src_idx;
  logic                                dst_found;
  logic [l2fwd_pkg::PORT_W-1:0]        dst_port;

  logic [l2fwd_pkg::PORT_W-1:0]        ingress_q;
  logic [l2fwd_pkg::MAC_W-1:0]         dst_q;
  logic [l2fwd_pkg::MAC_W-1:0]         src_q;
  logic                                tagged_q;
  logic [l2fwd_pkg::VID_W-1:0]         vid_q;

  logic [l2fwd_pkg::MODE_REG_W-1:0]    port_mode;
  logic [l2fwd_pkg::REG_W-1:0]         access_vlan;
  l2fwd_pkg::trunk_set_t               trunk_vlans;

  logic                                accept;
  logic                                cfg_wr;
  logic [2:0]                          cfg_idx;
  logic                                rd_en;
  l2fwd_pkg::entry_t                   rd_data;
  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  l2fwd_pkg::entry_t                   wr_data;
  logic                                full;
  logic                                learned;
  logic                                same_mac;
  logic                                bcast;
  logic                                hit;
  l2fwd_pkg::fwd_req_t                 req;
  logic [l2fwd_pkg::MASK_PORTS-1:0]    mask;
  logic                                src_match;
  logic                                dst_match;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[5:3];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_mode   <= '0;
      access_vlan <= '0;
      trunk_vlans <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        l2fwd_pkg::REG_PORT_MODE:   port_mode      <= pwdata[l2fwd_pkg::MODE_REG_W-1:0];
        l2fwd_pkg::REG_ACCESS_VLAN: access_vlan    <= pwdata[l2fwd_pkg::REG_W-1:0];
        l2fwd_pkg::REG_TRUNK0:      trunk_vlans[0] <= pwdata[l2fwd_pkg::REG_W-1:0];
        l2fwd_pkg::REG_TRUNK1:      trunk_vlans[1] <= pwdata[l2fwd_pkg::REG_W-1:0];
        l2fwd_pkg::REG_TRUNK2:      trunk_vlans[2] <= pwdata[l2fwd_pkg::REG_W-1:0];
        l2fwd_pkg::REG_TRUNK3:      trunk_vlans[3] <= pwdata[l2fwd_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      l2fwd_pkg::REG_PORT_MODE:   prdata = l2fwd_pkg::APB_DW'(port_mode);
      l2fwd_pkg::REG_ACCESS_VLAN: prdata = l2fwd_pkg::APB_DW'(access_vlan);
      l2fwd_pkg::REG_TRUNK0:      prdata = l2fwd_pkg::APB_DW'(trunk_vlans[0]);
      l2fwd_pkg::REG_TRUNK1:      prdata = l2fwd_pkg::APB_DW'(trunk_vlans[1]);
      l2fwd_pkg::REG_TRUNK2:      prdata = l2fwd_pkg::APB_DW'(trunk_vlans[2]);
      l2fwd_pkg::REG_TRUNK3:      prdata = l2fwd_pkg::APB_DW'(trunk_vlans[3]);
      default:                    prdata = '0;
    endcase
  end

  // table access: valid entries are always the prefix below fill_count
  assign rd_en     = (state == ST_SCAN) && (scan_addr < fill_count);
  assign full      = (fill_count == CW'(TABLE_ENTRIES));
  assign learned   = src_found || !full;
  assign same_mac  = (dst_q == src_q);
  assign bcast     = &dst_q;
  assign hit       = !bcast && (same_mac ? learned : dst_found);
  assign wr_en     = (state == ST_WRITE) && learned;
  assign wr_addr   = src_found ? src_idx : fill_count[AW-1:0];
  assign wr_data   = '{key: src_q, port: ingress_q};
  assign src_match = rd_valid && (rd_data.key == src_q);
  assign dst_match = rd_valid && (rd_data.key == dst_q);

  assign req = '{flood:    !hit,
                 hit:      hit,
                 hit_port: same_mac ? ingress_q : dst_port,
                 ingress:  ingress_q,
                 has_tag:  tagged_q,
                 vid:      vid_q};

  l2fwd_table_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  l2fwd_egress_filter u_filter (
    .req         (req),
    .port_mode   (port_mode),
    .access_vlan (access_vlan),
    .trunk_vlans (trunk_vlans),
    .mask        (mask)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          rd_valid <= 1'b0;
          if (accept) begin
            state <= (fill_count == '0) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_valid <= rd_en;
          if (rd_valid && rd_last) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (!src_found && !full) begin
            fill_count <= fill_count + CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ingress_q <= ingress_port;
      dst_q     <= dst_mac;
      src_q     <= src_mac;
      tagged_q  <= vlan_tagged;
      vid_q     <= vlan_id;
      scan_addr <= '0;
      src_found <= 1'b0;
      dst_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (rd_en) begin
        scan_addr <= scan_addr + CW'(1);
      end
      rd_idx  <= scan_addr[AW-1:0];
      rd_last <= (scan_addr == fill_count - CW'(1));
      if (src_match && !src_found) begin
        src_found <= 1'b1;
        src_idx   <= rd_idx;
      end
      if (dst_match && !dst_found) begin
        dst_found <= 1'b1;
        dst_port  <= rd_data.port;
      end
    end
    if (state == ST_WRITE) begin
      egress_mask   <= mask;
      flooded       <= !hit;
      dst_hit       <= hit;
      learn_dropped <= !learned;
    end
  end

  `L2FWD_ASSERT_NOW(a_count_range, 1'b1, fill_count <= CW'(TABLE_ENTRIES))
  `L2FWD_ASSERT_NOW(a_read_valid_only, rd_en, scan_addr < fill_count)
  `L2FWD_ASSERT_NEXT(a_accept_busy, accept, busy)
  `L2FWD_ASSERT_NOW(a_done_idle, done, !busy)
  `L2FWD_ASSERT_NOW(a_flood_xor_hit, done, flooded != dst_hit)
  `L2FWD_ASSERT_NOW(a_drop_full, done && learn_dropped, full)

endmodule
